// ===== rtl/core/tkns_pkg.sv =====
// Shared types and constants for the top-k neighbor select unit.
package tkns_pkg;

  localparam int KEEP_W    = 6;
  localparam int SCORE_W   = 32;
  localparam int NBR_IDX_W = 16;
  localparam int RANK_W    = 5;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 6'd32;

  // Output tuser: rank in the low bits, then the empty-row flag, padded to a byte.
  localparam int OUT_TDATA_W = ((NBR_IDX_W + SCORE_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = ((RANK_W + 1 + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  typedef struct packed {
    logic take_item;  // input transaction this cycle
    logic emit_step;  // load the next result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a result
    logic emit_last;  // the result loaded now is the last of the row
  } dp_status_t;

endpackage

// ===== rtl/core/top_k_neighbor_select_unit.sv =====
// Top level of the streaming top-k neighbor select unit.
// Scores of one similarity-matrix row stream in one per cycle; self-matches
// (column equal to row) are dropped and the best keep_count entries, at most MAX_KEEP,
// are held sorted in a row of compare-and-shift cells, higher score first and lower
// column first on ties, so each score is inserted in the cycle it is accepted.
// After the transaction that carries tlast the unit stops accepting and emits
// the kept entries best first, one per cycle while the output side is ready,
// tlast on the final one (a row that kept nothing gives one result with the
// empty flag set). Emission runs from the head of the cell row through the single
// output register. keep_count must be written only between rows; the unit itself
// does not enforce this.
module top_k_neighbor_select_unit
  import tkns_pkg::*;
#(
  parameter int MAX_KEEP   = 32,
  parameter int INDEX_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [KEEP_W-1:0]      cfg_wdata_i,   // keep_count
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // row_index, column_index, score (low bits up), zero padded to bytes
  input  logic [((2*INDEX_BITS+SCORE_W+7)/8)*8-1:0] s_axis_tdata,
  input  logic                   s_axis_tlast,  // row_end
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // neighbor_index, neighbor_score
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,  // rank, empty_row
  output logic                   m_axis_tlast   // last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  logic [NBR_IDX_W-1:0]      nbr_idx;
  logic signed [SCORE_W-1:0] nbr_score;
  logic [RANK_W-1:0]         rank;
  logic                      empty_row;

  tkns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_end_i   (s_axis_tlast),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  tkns_datapath #(
    .MAX_KEEP   (MAX_KEEP),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .row_index_i      (s_axis_tdata[INDEX_BITS-1:0]),
    .column_index_i   (s_axis_tdata[2*INDEX_BITS-1:INDEX_BITS]),
    .score_i          (s_axis_tdata[2*INDEX_BITS+SCORE_W-1:2*INDEX_BITS]),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .neighbor_index_o (nbr_idx),
    .neighbor_score_o (nbr_score),
    .rank_o           (rank),
    .empty_row_o      (empty_row),
    .last_o           (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_TDATA_W'({nbr_score, nbr_idx});
  assign m_axis_tuser = OUT_TUSER_W'({empty_row, rank});

  // A row end closes the input until the emission pass is done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still open after a row end transaction");

  // Scanning and emission never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.take_item && cmd.emit_step))
    else $error("insertion and emission in the same cycle");

  // An empty-row result is the only one of its row and carries zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && empty_row |-> m_axis_tlast && (rank == '0) && (nbr_idx == '0)
      && (nbr_score == '0))
    else $error("malformed empty-row result");

endmodule

// ===== rtl/core/tkns_ctrl.sv =====
// Controller: scan a row, then step through the emission of its kept entries.
module tkns_ctrl
  import tkns_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_end_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.take_item = in_valid_i;
        if (in_valid_i && in_end_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit_step = status_i.out_free;
        if (status_i.out_free && status_i.emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/tkns_datapath.sv =====
// Datapath: sorted insertion cell row, keep-count register and output register.
module tkns_datapath
  import tkns_pkg::*;
#(
  parameter int MAX_KEEP   = 32,
  parameter int INDEX_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [KEEP_W-1:0]            cfg_wdata_i,
  input  dp_cmd_t                      cmd_i,
  output dp_status_t                   status_o,
  input  logic [INDEX_BITS-1:0]        row_index_i,
  input  logic [INDEX_BITS-1:0]        column_index_i,
  input  logic signed [SCORE_W-1:0]    score_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [NBR_IDX_W-1:0]         neighbor_index_o,
  output logic signed [SCORE_W-1:0]    neighbor_score_o,
  output logic [RANK_W-1:0]            rank_o,
  output logic                         empty_row_o,
  output logic                         last_o
);

  localparam int CntW = $clog2(MAX_KEEP + 1);
  localparam int CmpW = (CntW > KEEP_W) ? CntW : KEEP_W;

  logic [KEEP_W-1:0] keep_q;
  logic [CntW-1:0]   fill_q, fill_d;
  logic [CntW-1:0]   rank_q, rank_d;
  logic [CntW-1:0]   limit, fill_eff;
  logic [CmpW-1:0]   keep_ext, max_ext;
  logic              self_match;

  logic [INDEX_BITS-1:0]     col_q   [MAX_KEEP];
  logic signed [SCORE_W-1:0] score_q [MAX_KEEP];
  logic [MAX_KEEP-1:0]       goes;

  assign keep_ext   = CmpW'(keep_q);
  assign max_ext    = CmpW'(MAX_KEEP);
  assign limit      = (keep_ext > max_ext) ? CntW'(max_ext) : CntW'(keep_ext);
  assign fill_eff   = (fill_q > limit) ? limit : fill_q;
  assign self_match = (row_index_i == column_index_i);

  // The new entry belongs at or ahead of cell i; sorted order makes this a suffix.
  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      goes[i] = (CntW'(i) >= fill_eff) ||
                (score_i > score_q[i]) ||
                ((score_i == score_q[i]) && (column_index_i < col_q[i]));
    end
  end

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic                      prev_goes;
    logic [INDEX_BITS-1:0]     prev_col, next_col;
    logic signed [SCORE_W-1:0] prev_score, next_score;
    logic                      write_en;

    if (i == 0) begin : g_first
      assign prev_goes  = 1'b0;
      assign prev_col   = col_q[i];
      assign prev_score = score_q[i];
    end else begin : g_mid
      assign prev_goes  = goes[i-1];
      assign prev_col   = col_q[i-1];
      assign prev_score = score_q[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign next_col   = col_q[i];
      assign next_score = score_q[i];
    end else begin : g_body
      assign next_col   = col_q[i+1];
      assign next_score = score_q[i+1];
    end

    assign write_en = cmd_i.take_item && !self_match && (CntW'(i) < limit);

    always_ff @(posedge clk_i) begin
      if (cmd_i.emit_step) begin
        // advance toward the head while emitting
        col_q[i]   <= next_col;
        score_q[i] <= next_score;
      end else if (write_en) begin
        if (prev_goes) begin
          col_q[i]   <= prev_col;
          score_q[i] <= prev_score;
        end else if (goes[i]) begin
          col_q[i]   <= column_index_i;
          score_q[i] <= score_i;
        end
      end
    end
  end

  assign status_o.emit_last = (fill_eff == '0) || ((rank_q + CntW'(1)) == fill_eff);

  always_comb begin
    fill_d = fill_q;
    rank_d = rank_q;
    if (cmd_i.take_item && !self_match) begin
      fill_d = (fill_eff < limit) ? fill_eff + CntW'(1) : fill_eff;
    end
    if (cmd_i.emit_step) begin
      if (status_o.emit_last) begin
        fill_d = '0;
        rank_d = '0;
      end else begin
        rank_d = rank_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= KEEP_RESET;
      fill_q <= '0;
      rank_q <= '0;
    end else begin
      if (cfg_we_i) begin
        keep_q <= cfg_wdata_i;
      end
      fill_q <= fill_d;
      rank_q <= rank_d;
    end
  end

  // Output register
  logic                      out_valid_q;
  logic [NBR_IDX_W-1:0]      out_idx_q;
  logic signed [SCORE_W-1:0] out_score_q;
  logic [RANK_W-1:0]         out_rank_q;
  logic                      out_empty_q, out_last_q;
  logic [NBR_IDX_W+INDEX_BITS-1:0] col_ext;
  logic [RANK_W+CntW-1:0]          rank_ext;
  logic                            is_empty;

  assign col_ext  = {{NBR_IDX_W{1'b0}}, col_q[0]};
  assign rank_ext = {{RANK_W{1'b0}}, rank_q};
  assign is_empty = (fill_eff == '0);

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_step) begin
      out_idx_q   <= is_empty ? '0 : col_ext[NBR_IDX_W-1:0];
      out_score_q <= is_empty ? '0 : score_q[0];
      out_rank_q  <= is_empty ? '0 : rank_ext[RANK_W-1:0];
      out_empty_q <= is_empty;
      out_last_q  <= status_o.emit_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign neighbor_index_o = out_idx_q;
  assign neighbor_score_o = out_score_q;
  assign rank_o           = out_rank_q;
  assign empty_row_o      = out_empty_q;
  assign last_o           = out_last_q;

endmodule

// ===== tb/sv/tb_top_k_neighbor_select_unit.sv =====
// Self-checking stream testbench for the top-k neighbor select unit.
module tb_top_k_neighbor_select_unit;
  import tkns_pkg::*;

  localparam int IDX_W      = 16;
  localparam int KEEP_MAX   = 32;
  localparam int IN_TDATA_W = ((2*IDX_W + SCORE_W + 7) / 8) * 8;

  typedef struct {
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic signed [SCORE_W-1:0] score;
    logic                      row_end;
  } score_cell_t;

  typedef struct {
    logic [NBR_IDX_W-1:0]      idx;
    logic signed [SCORE_W-1:0] score;
    logic [RANK_W-1:0]         rank;
    logic                      empty_row;
    logic                      last;
  } neighbor_t;

  // Sorted neighbor store plus the queue of neighbors still owed by the unit.
  class neighbor_scoreboard;
    logic [KEEP_W-1:0]         keep_count;
    logic [IDX_W-1:0]          kept_col [KEEP_MAX];
    logic signed [SCORE_W-1:0] kept_val [KEEP_MAX];
    int                        kept_fill;
    neighbor_t                 pending_nbrs[$];
    int                        errors;
    int                        results_seen;
    int                        rows_done;
    int                        empty_rows;

    function new();
      keep_count   = KEEP_RESET;
      kept_fill    = 0;
      errors       = 0;
      results_seen = 0;
      rows_done    = 0;
      empty_rows   = 0;
    endfunction

    function int keep_limit();
      return (keep_count > KEEP_MAX) ? KEEP_MAX : int'(keep_count);
    endfunction

    function bit ranks_ahead(input logic [IDX_W-1:0] col_a,
                             input logic signed [SCORE_W-1:0] val_a,
                             input logic [IDX_W-1:0] col_b,
                             input logic signed [SCORE_W-1:0] val_b);
      if (val_a != val_b) return val_a > val_b;
      return col_a < col_b;
    endfunction

    function void insert_score(input logic [IDX_W-1:0] col,
                               input logic signed [SCORE_W-1:0] val);
      int limit;
      int pos;
      int i;
      limit = keep_limit();
      pos   = 0;
      if (kept_fill > limit) kept_fill = limit;
      if (limit == 0) return;
      while (pos < kept_fill && !ranks_ahead(col, val, kept_col[pos], kept_val[pos])) pos++;
      if (pos >= limit) return;
      // shift worse entries down, dropping the worst when the store is full
      i = (kept_fill < limit) ? kept_fill : limit - 1;
      while (i > pos) begin
        kept_col[i] = kept_col[i-1];
        kept_val[i] = kept_val[i-1];
        i--;
      end
      kept_col[pos] = col;
      kept_val[pos] = val;
      if (kept_fill < limit) kept_fill++;
    endfunction

    function void note_score(input score_cell_t txn);
      neighbor_t nb;
      int        n;
      if (txn.row != txn.col) insert_score(txn.col, txn.score);
      if (!txn.row_end) return;
      rows_done++;
      n = kept_fill;
      if (n > keep_limit()) n = keep_limit();
      kept_fill = 0;
      if (n == 0) begin
        nb.idx       = '0;
        nb.score     = '0;
        nb.rank      = '0;
        nb.empty_row = 1'b1;
        nb.last      = 1'b1;
        pending_nbrs.push_back(nb);
        empty_rows++;
        return;
      end
      for (int k = 0; k < n; k++) begin
        nb.idx       = kept_col[k];
        nb.score     = kept_val[k];
        nb.rank      = RANK_W'(k);
        nb.empty_row = 1'b0;
        nb.last      = (k == n - 1);
        pending_nbrs.push_back(nb);
      end
    endfunction

    function void check_neighbor(input neighbor_t got);
      neighbor_t want;
      results_seen++;
      if (pending_nbrs.size() == 0) begin
        $error("unexpected neighbor: index %0d score %0h rank %0d empty_row %0b last %0b",
               got.idx, got.score, got.rank, got.empty_row, got.last);
        errors++;
        return;
      end
      want = pending_nbrs.pop_front();
      if (got.idx !== want.idx) begin
        $error("neighbor_index: expected %0d, got %0d", want.idx, got.idx);
        errors++;
      end
      if (got.score !== want.score) begin
        $error("neighbor_score: expected %0h, got %0h", want.score, got.score);
        errors++;
      end
      if (got.rank !== want.rank) begin
        $error("rank: expected %0d, got %0d", want.rank, got.rank);
        errors++;
      end
      if (got.empty_row !== want.empty_row) begin
        $error("empty_row: expected %0b, got %0b", want.empty_row, got.empty_row);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [KEEP_W-1:0]      cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;

  neighbor_scoreboard sb = new();
  int idle_pct  = 0;
  int stall_pct = 0;
  int scores_sent = 0;
  int keep_writes = 0;

  top_k_neighbor_select_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Check each output transaction with the values sampled at the edge, then pick the
  // next ready level.
  always @(posedge clk_i) begin
    neighbor_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.idx       = m_axis_tdata[NBR_IDX_W-1:0];
      got.score     = m_axis_tdata[NBR_IDX_W +: SCORE_W];
      got.rank      = m_axis_tuser[RANK_W-1:0];
      got.empty_row = m_axis_tuser[RANK_W];
      got.last      = m_axis_tlast;
      sb.check_neighbor(got);
    end
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_score(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                            input logic [SCORE_W-1:0] score, input logic row_end);
    score_cell_t txn;
    txn.row     = row;
    txn.col     = col;
    txn.score   = score;
    txn.row_end = row_end;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {score, col, row};
    s_axis_tlast  <= row_end;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_score(txn);
    scores_sent++;
  endtask

  // Narrow rows draw from few columns and scores to force ties and self-matches.
  task automatic send_row(input int len);
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [SCORE_W-1:0] score;
    bit                 narrow;
    narrow = 1'($urandom_range(1));
    row    = narrow ? IDX_W'($urandom_range(7)) : IDX_W'($urandom());
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) col = row;
      else if (narrow) col = IDX_W'($urandom_range(7));
      else col = IDX_W'($urandom());
      if (narrow) score = SCORE_W'($urandom_range(4)) * 32'h8000 - 32'h10000;
      else score = $urandom();
      send_score(row, col, score, i == len - 1);
    end
  endtask

  // Hold the input side until every owed neighbor is out, then let the unit settle.
  task automatic wait_idle(input int settle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_nbrs.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.keep_count = value;
    keep_writes++;
  endtask

  initial begin
    int keep_plan [12] = '{32, 1, 0, 63, 5, 2, 33, 16, 31, 3, 7, 32};
    int idle_plan [4]  = '{0, 79, 0, 24};
    int stall_plan [4] = '{0, 0, 79, 24};
    int seg_start;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset keep count: score extremes, tie on score, exact tie, self-match dropped.
    send_score(16'h0005, 16'h0000, 32'h7FFF_FFFF, 1'b0);
    send_score(16'h0005, 16'hFFFF, 32'h8000_0000, 1'b0);
    send_score(16'h0005, 16'h0002, 32'h0001_0000, 1'b0);
    send_score(16'h0005, 16'h0001, 32'h0001_0000, 1'b0);
    send_score(16'h0005, 16'h0005, 32'h7FFF_FFFF, 1'b0);
    send_score(16'h0005, 16'h0003, 32'h0001_0000, 1'b0);
    send_score(16'h0005, 16'h0003, 32'h0001_0000, 1'b0);
    send_score(16'h0005, 16'h0004, 32'h0000_0000, 1'b1);
    // Row of only a self-match gives the empty result.
    send_score(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 1'b1);
    // Self-match on the row end still emits the row.
    send_score(16'h0000, 16'h0009, 32'hFFFF_FFFF, 1'b0);
    send_score(16'h0000, 16'h0000, 32'h0000_0005, 1'b1);
    wait_idle(8);
    write_keep(6'd0);
    send_score(16'h1234, 16'h0001, 32'h0000_0100, 1'b0);
    send_score(16'h1234, 16'h0002, 32'h0000_0200, 1'b1);
    wait_idle(8);
    write_keep(6'd1);
    send_score(16'hAAAA, 16'h5555, 32'hFFFF_0000, 1'b0);
    send_score(16'hAAAA, 16'h0010, 32'h0000_8000, 1'b0);
    send_score(16'hAAAA, 16'h0011, 32'h0000_8000, 1'b0);
    send_score(16'hAAAA, 16'h000F, 32'h0000_4000, 1'b1);
    wait_idle(8);
    write_keep(6'd63);
    send_score(16'h5555, 16'hAAAA, 32'h1234_5678, 1'b0);
    send_score(16'h5555, 16'h0001, 32'hEDCB_A987, 1'b0);
    send_score(16'h5555, 16'h0002, 32'h0000_0000, 1'b0);
    send_score(16'h5555, 16'h0003, 32'h0000_0000, 1'b0);
    send_score(16'h5555, 16'h0004, 32'h7FFF_0000, 1'b0);
    send_score(16'h5555, 16'h0005, 32'h8000_FFFF, 1'b1);
    wait_idle(8);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_plan[phase];
      stall_pct = stall_plan[phase];
      for (int seg = 0; seg < 3; seg++) begin
        write_keep(KEEP_W'(keep_plan[phase*3 + seg]));
        seg_start = scores_sent;
        while (scores_sent - seg_start < 5) begin
          send_row(($urandom_range(15) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 8));
          // hold the sender once until the unit has drained completely
          if (phase == 1 && seg == 0 && scores_sent - seg_start >= 3) begin
            wait_idle(0);
            seg_start = seg_start - 15;
          end
        end
        wait_idle(8);
      end
      // keep a stretch free of idling and stalling between phases
      idle_pct  = 0;
      stall_pct = 0;
      send_row($urandom_range(1, 6));
      wait_idle(8);
    end

    wait_idle(16);
    $display("covered %0d scores in %0d rows (%0d empty), %0d keep_count writes",
             scores_sent, sb.rows_done, sb.empty_rows, keep_writes);
    $display("checked %0d neighbor results under four idle and stall mixes",
             sb.results_seen);
    if (sb.errors == 0) begin
      $display("[top_k_neighbor_select_unit] OK");
    end else begin
      $display("[top_k_neighbor_select_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[top_k_neighbor_select_unit] ERROR");
    $finish;
  end

endmodule
